// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every rising edge outside reset
`define RFX_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rfx assertion failed");
// condition in one cycle implies result in the next
`define RFX_ASSERT_NEXT(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error("rfx assertion failed");
`else
`define RFX_ASSERT(label, clk, rst, prop)
`define RFX_ASSERT_NEXT(label, clk, rst, cond, result)
`endif
`endif

// File: rtl/rfx_pkg.sv
// types, codes and constants of the r-type execute block
package rfx_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 5;
   localparam int FN_W        = 6;
   localparam int REG_COUNT   = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int PC_STEP     = 4;

   localparam logic [FN_W-1:0] FN_SLL  = 6'h00;
   localparam logic [FN_W-1:0] FN_SRL  = 6'h02;
   localparam logic [FN_W-1:0] FN_SRA  = 6'h03;
   localparam logic [FN_W-1:0] FN_JR   = 6'h08;
   localparam logic [FN_W-1:0] FN_ADD  = 6'h20;
   localparam logic [FN_W-1:0] FN_ADDU = 6'h21;
   localparam logic [FN_W-1:0] FN_SUB  = 6'h22;
   localparam logic [FN_W-1:0] FN_SUBU = 6'h23;
   localparam logic [FN_W-1:0] FN_AND  = 6'h24;
   localparam logic [FN_W-1:0] FN_OR   = 6'h25;
   localparam logic [FN_W-1:0] FN_XOR  = 6'h26;
   localparam logic [FN_W-1:0] FN_NOR  = 6'h27;
   localparam logic [FN_W-1:0] FN_NAND = 6'h28;
   localparam logic [FN_W-1:0] FN_SLT  = 6'h2A;
   localparam logic [FN_W-1:0] FN_SLTU = 6'h2B;

   typedef enum logic [3:0] {
      OP_ADD, OP_ADDU, OP_SUB, OP_SUBU,
      OP_AND, OP_OR, OP_XOR, OP_NOR, OP_NAND,
      OP_SLT, OP_SLTU, OP_SLL, OP_SRL, OP_SRA,
      OP_JR, OP_UNKNOWN
   } op_type;

   typedef struct packed {
      logic [FN_W-1:0]  function_code;
      logic [IDX_W-1:0] source_index;
      logic [IDX_W-1:0] second_index;
      logic [IDX_W-1:0] dest_index;
      logic [IDX_W-1:0] shift_amount;
   } req_payload_type;

   typedef struct packed {
      logic              wrote_register;
      logic [IDX_W-1:0]  written_index;
      logic [DATA_W-1:0] written_value;
      logic [DATA_W-1:0] next_pc;
      logic              overflow_flag;
      logic              unknown_function;
   } rsp_payload_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] rs;
      logic [IDX_W-1:0] rt;
      logic [IDX_W-1:0] rd;
      logic [IDX_W-1:0] sh;
   } decoded_type;

endpackage

// File: rtl/rfx_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface rfx_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rfx_front.sv
// front stage: accepts instructions and decodes the function code
module rfx_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rfx_pkg::req_payload_type req_payload,
   output logic                     dec_valid,
   input  logic                     dec_ready,
   output rfx_pkg::decoded_type     dec_item
);

   function automatic rfx_pkg::op_type decode_op(input logic [rfx_pkg::FN_W-1:0] fn);
      rfx_pkg::op_type op;
      case (fn)
         rfx_pkg::FN_ADD:  op = rfx_pkg::OP_ADD;
         rfx_pkg::FN_ADDU: op = rfx_pkg::OP_ADDU;
         rfx_pkg::FN_SUB:  op = rfx_pkg::OP_SUB;
         rfx_pkg::FN_SUBU: op = rfx_pkg::OP_SUBU;
         rfx_pkg::FN_AND:  op = rfx_pkg::OP_AND;
         rfx_pkg::FN_OR:   op = rfx_pkg::OP_OR;
         rfx_pkg::FN_XOR:  op = rfx_pkg::OP_XOR;
         rfx_pkg::FN_NOR:  op = rfx_pkg::OP_NOR;
         rfx_pkg::FN_NAND: op = rfx_pkg::OP_NAND;
         rfx_pkg::FN_SLT:  op = rfx_pkg::OP_SLT;
         rfx_pkg::FN_SLTU: op = rfx_pkg::OP_SLTU;
         rfx_pkg::FN_SLL:  op = rfx_pkg::OP_SLL;
         rfx_pkg::FN_SRL:  op = rfx_pkg::OP_SRL;
         rfx_pkg::FN_SRA:  op = rfx_pkg::OP_SRA;
         rfx_pkg::FN_JR:   op = rfx_pkg::OP_JR;
         default:          op = rfx_pkg::OP_UNKNOWN;
      endcase
      return op;
   endfunction

   logic                 dec_valid_ff;
   rfx_pkg::decoded_type dec_item_ff;
   rfx_pkg::decoded_type dec_item_in;
   logic                 accept;

   assign req_ready = !dec_valid_ff || dec_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dec_item_in.op = decode_op(req_payload.function_code);
      dec_item_in.rs = req_payload.source_index;
      dec_item_in.rt = req_payload.second_index;
      dec_item_in.rd = req_payload.dest_index;
      dec_item_in.sh = req_payload.shift_amount;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (accept) begin
         dec_valid_ff <= 1'b1;
      end else if (dec_ready) begin
         dec_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_item_ff <= dec_item_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec_item  = dec_item_ff;

endmodule

// File: rtl/rfx_queue.sv
// small fifo of decoded instructions between front and back
`include "assert_macros.svh"

module rfx_queue #(
   parameter int DEPTH = rfx_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rfx_pkg::decoded_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rfx_pkg::decoded_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rfx_pkg::decoded_type slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 push;
   logic                 pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `RFX_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule

// File: rtl/rfx_back.sv
// back stage: register file read, alu, register write-back and program counter
`include "assert_macros.svh"

module rfx_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  rfx_pkg::decoded_type     pop_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rfx_pkg::rsp_payload_type rsp_payload
);

   localparam int DW = rfx_pkg::DATA_W;
   localparam int IW = rfx_pkg::IDX_W;

   // register file and its per-entry written flags
   logic [DW-1:0]                 reg_file_ff [rfx_pkg::REG_COUNT];
   logic [rfx_pkg::REG_COUNT-1:0] reg_valid_ff;

   // execute stage
   logic                     exec_valid_ff;
   rfx_pkg::decoded_type     exec_item_ff;
   logic [DW-1:0]            a_mem_ff;
   logic [DW-1:0]            b_mem_ff;
   logic                     a_byp_ff;
   logic                     b_byp_ff;
   logic                     a_zero_ff;
   logic                     b_zero_ff;
   logic [DW-1:0]            byp_data_ff;
   logic [DW-1:0]            pc_ff;
   logic                     rsp_valid_ff;
   rfx_pkg::rsp_payload_type rsp_payload_ff;
   rfx_pkg::rsp_payload_type rsp_payload_in;

   logic          pop;
   logic          exec_fire;
   logic [DW-1:0] a;
   logic [DW-1:0] b;
   logic          is_sub;
   logic [DW:0]   sum;
   logic [DW-1:0] val;
   logic          ovf;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] pc_in;
   logic          pc_load;

   assign exec_fire = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !exec_valid_ff || exec_fire;
   assign pop       = pop_valid && pop_ready;

   // operands: registered read, bypassed from a write in the read cycle
   assign a = a_byp_ff ? byp_data_ff : (a_zero_ff ? '0 : a_mem_ff);
   assign b = b_byp_ff ? byp_data_ff : (b_zero_ff ? '0 : b_mem_ff);

   // one shared adder for add, sub and the compares
   always_comb begin
      case (exec_item_ff.op)
         rfx_pkg::OP_SUB, rfx_pkg::OP_SUBU,
         rfx_pkg::OP_SLT, rfx_pkg::OP_SLTU: is_sub = 1'b1;
         default:                          is_sub = 1'b0;
      endcase
      sum = {1'b0, a} + {1'b0, (is_sub ? ~b : b)} + {{DW{1'b0}}, is_sub};
   end

   always_comb begin
      val   = '0;
      ovf   = 1'b0;
      wr_en = 1'b0;
      case (exec_item_ff.op)
         rfx_pkg::OP_ADD: begin
            val = sum[DW-1:0];
            ovf = (a[DW-1] ^ val[DW-1]) & (b[DW-1] ^ val[DW-1]);
         end
         rfx_pkg::OP_SUB: begin
            val = sum[DW-1:0];
            ovf = (a[DW-1] ^ b[DW-1]) & (a[DW-1] ^ val[DW-1]);
         end
         rfx_pkg::OP_ADDU: begin
            val = sum[DW-1:0];
            ovf = sum[DW];
         end
         rfx_pkg::OP_SUBU: begin
            val = sum[DW-1:0];
            ovf = !sum[DW];
         end
         rfx_pkg::OP_AND:  val = a & b;
         rfx_pkg::OP_OR:   val = a | b;
         rfx_pkg::OP_XOR:  val = a ^ b;
         rfx_pkg::OP_NOR:  val = ~(a | b);
         rfx_pkg::OP_NAND: val = ~(a & b);
         rfx_pkg::OP_SLT:
            val = DW'((a[DW-1] ^ b[DW-1]) ? a[DW-1] : sum[DW-1]);
         rfx_pkg::OP_SLTU: val = DW'(!sum[DW]);
         rfx_pkg::OP_SLL:  val = b << exec_item_ff.sh;
         rfx_pkg::OP_SRL:  val = b >> exec_item_ff.sh;
         rfx_pkg::OP_SRA:  val = $unsigned($signed(b) >>> exec_item_ff.sh);
         default: ;
      endcase
      case (exec_item_ff.op)
         rfx_pkg::OP_JR, rfx_pkg::OP_UNKNOWN: wr_en = 1'b0;
         default:                             wr_en = 1'b1;
      endcase
   end

   assign wr_addr = exec_item_ff.rd;
   assign pc_load = exec_fire && (exec_item_ff.op != rfx_pkg::OP_UNKNOWN);
   assign pc_in   = wr_en ? pc_ff + DW'(rfx_pkg::PC_STEP) : a;

   always_comb begin
      rsp_payload_in.wrote_register   = wr_en;
      rsp_payload_in.written_index    = wr_en ? wr_addr : '0;
      rsp_payload_in.written_value    = wr_en ? val : '0;
      rsp_payload_in.next_pc          = (exec_item_ff.op == rfx_pkg::OP_UNKNOWN) ? pc_ff : pc_in;
      rsp_payload_in.overflow_flag    = ovf;
      rsp_payload_in.unknown_function = exec_item_ff.op == rfx_pkg::OP_UNKNOWN;
   end

   // register file write and registered reads
   always_ff @(posedge clock) begin
      if (exec_fire && wr_en) begin
         reg_file_ff[wr_addr] <= val;
      end
      if (pop) begin
         a_mem_ff <= reg_file_ff[pop_item.rs];
         b_mem_ff <= reg_file_ff[pop_item.rt];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (exec_fire && wr_en) begin
         reg_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         exec_item_ff <= pop_item;
         a_byp_ff     <= exec_fire && wr_en && (wr_addr == pop_item.rs);
         b_byp_ff     <= exec_fire && wr_en && (wr_addr == pop_item.rt);
         a_zero_ff    <= !reg_valid_ff[pop_item.rs];
         b_zero_ff    <= !reg_valid_ff[pop_item.rt];
         byp_data_ff  <= val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pc_ff         <= '0;
      end else begin
         if (pop) begin
            exec_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            exec_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pc_load) begin
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `RFX_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, exec_fire, rsp_valid_ff)
   `RFX_ASSERT_NEXT(a_write_marks_valid, clock, reset, exec_fire && wr_en, reg_valid_ff[$past(wr_addr)])
   `RFX_ASSERT_NEXT(a_unknown_keeps_pc, clock, reset, exec_fire && (exec_item_ff.op == rfx_pkg::OP_UNKNOWN), $stable(pc_ff))
   `RFX_ASSERT(a_unknown_no_write, clock, reset, !(rsp_valid_ff && rsp_payload_ff.unknown_function && rsp_payload_ff.wrote_register))

endmodule

// File: rtl/rtype_alu_register_file.sv
// top level of the r-type execute block with register file and program counter
// usage:
// - req_stream carries one r-type instruction per transaction
//   (function code, rs, rt, rd, shift amount); valid/ready handshake
// - rsp_stream returns exactly one result per instruction, in order: write flag,
//   written register and value, next program counter, overflow and unknown flags
// - from the accepting edge to rsp valid with an empty pipeline, an instruction passes
//   the decode register, the queue, the register file read and execute, the output register
// - throughput is one instruction per cycle while the receiver does not stall; the register
//   file is read into the execute stage registers and a write in the read cycle is bypassed
// - the program counter and register file update as each instruction executes,
//   so dependent instructions can follow back to back
// - when the receiver stalls, the output register holds its result, the execute
//   stage holds, the queue fills and then req ready drops; nothing is lost
// - reset (synchronous, active high) clears the program counter, marks every
//   register as zero and empties all stages
module rtype_alu_register_file #(
   parameter int QUEUE_DEPTH = rfx_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   rfx_stream_if.sink   req_stream,
   rfx_stream_if.source rsp_stream
);

   // front to queue
   logic                 dec_valid;
   logic                 dec_ready;
   rfx_pkg::decoded_type dec_item;

   // queue to back
   logic                 pop_valid;
   logic                 pop_ready;
   rfx_pkg::decoded_type pop_item;

   // front: takes the transaction and classifies the function code
   rfx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_stream.valid),
      .req_ready   (req_stream.ready),
      .req_payload (req_stream.payload),
      .dec_valid   (dec_valid),
      .dec_ready   (dec_ready),
      .dec_item    (dec_item)
   );

   // queue: lets the front keep accepting while the back is stalled
   rfx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_item  (dec_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back: register file, alu, program counter and output register
   rfx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_valid   (rsp_stream.valid),
      .rsp_ready   (rsp_stream.ready),
      .rsp_payload (rsp_stream.payload)
   );

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench of the r-type execute block with register file and program counter
`timescale 1ns / 1ps

module tb_top;
   import rfx_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TIME  = 24;
   localparam int PRINT_LIMIT  = 100;
   localparam int REQ_W        = $bits(req_payload_type);

   // every supported function code, for picking operations at random
   localparam logic [FN_W-1:0] KNOWN_FN [15] = '{
      FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
      FN_AND, FN_OR, FN_XOR, FN_NOR, FN_NAND, FN_SLT, FN_SLTU
   };

   // one instruction waiting to be sent; hold marks a wait for every result first
   typedef struct {
      req_payload_type instr;
      bit              hold;
   } pending_type;

   logic clock;
   logic reset;

   rfx_stream_if #(.payload_type(req_payload_type)) req_if ();
   rfx_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   rtype_alu_register_file u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   // instructions still to send and results still to arrive
   pending_type     instr_q [$];
   rsp_payload_type result_q [$];

   // own copy of the architectural state
   logic [DATA_W-1:0] gpr_model [REG_COUNT];
   logic [DATA_W-1:0] pc_model;

   // idling controls, changed from phase to phase
   int  req_gap_pct;
   int  rsp_stall_pct;
   int  gap_left;
   int  stall_left;
   bit  req_taken;
   int  error_count;
   int  cycle_count;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // prints one line per mismatch, quietly counting once the print limit is hit
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // executes one instruction on the model state and returns the result it must produce
   function automatic rsp_payload_type execute_instr(input req_payload_type instr);
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] val;
      logic [DATA_W:0]   wide;
      logic              write;
      logic              ovf;
      logic              unknown;
      rsp_payload_type   res;
      a       = gpr_model[instr.source_index];
      b       = gpr_model[instr.second_index];
      val     = '0;
      write   = 1'b1;
      ovf     = 1'b0;
      unknown = 1'b0;
      case (instr.function_code)
         FN_ADD: begin
            val = a + b;
            // same operand signs, result sign differs
            ovf = (a[31] == b[31]) && (val[31] != a[31]);
         end
         FN_SUB: begin
            val = a - b;
            ovf = (a[31] != b[31]) && (val[31] != a[31]);
         end
         FN_ADDU: begin
            wide = {1'b0, a} + {1'b0, b};
            val  = wide[DATA_W-1:0];
            ovf  = wide[DATA_W];
         end
         FN_SUBU: begin
            val = a - b;
            ovf = a < b;
         end
         FN_AND:  val = a & b;
         FN_OR:   val = a | b;
         FN_XOR:  val = a ^ b;
         FN_NOR:  val = ~(a | b);
         FN_NAND: val = ~(a & b);
         FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
         FN_SLL:  val = b << instr.shift_amount;
         FN_SRL:  val = b >> instr.shift_amount;
         FN_SRA:  val = $signed(b) >>> instr.shift_amount;
         FN_JR:   write = 1'b0;
         default: begin
            write   = 1'b0;
            unknown = 1'b1;
         end
      endcase
      if (write) begin
         gpr_model[instr.dest_index] = val;
         pc_model = pc_model + PC_STEP;
      end else if (!unknown) begin
         // jump register takes rs as it is, no alignment
         pc_model = a;
      end
      res.wrote_register   = write;
      res.written_index    = write ? instr.dest_index : '0;
      res.written_value    = write ? val : '0;
      res.next_pc          = pc_model;
      res.overflow_flag    = ovf;
      res.unknown_function = unknown;
      return res;
   endfunction

   function automatic req_payload_type make_instr(input logic [FN_W-1:0] fn,
         input int rs, input int rt, input int rd, input int sh);
      req_payload_type instr;
      instr.function_code = fn;
      instr.source_index  = IDX_W'(rs);
      instr.second_index  = IDX_W'(rt);
      instr.dest_index    = IDX_W'(rd);
      instr.shift_amount  = IDX_W'(sh);
      return instr;
   endfunction

   // mostly supported operations, some fully random codes to hit the unknown path
   function automatic req_payload_type random_instr();
      logic [FN_W-1:0] fn;
      if ($urandom_range(0, 99) < 85)
         fn = KNOWN_FN[$urandom_range(0, 14)];
      else
         fn = FN_W'($urandom_range(0, 63));
      return make_instr(fn, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 31));
   endfunction

   task automatic push_instr(input req_payload_type instr, input bit hold);
      pending_type entry;
      entry.instr = instr;
      entry.hold  = hold;
      instr_q.push_back(entry);
   endtask

   // waits until the driver has taken every queued instruction
   task automatic wait_sent();
      while (instr_q.size() > 0)
         @(posedge clock);
   endtask

   // one random phase with its own idling mix; hold makes the sender drain first
   task automatic run_phase(input int count, input int gap_pct, input int stall_pct,
                            input bit hold);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++)
         push_instr(random_instr(), hold && (i == 0));
      wait_sent();
   endtask

   // sender: presents the next instruction at the falling edge, idles in bursts
   always @(negedge clock) begin
      logic            next_valid;
      req_payload_type next_payload;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
      end else begin
         next_valid   = req_if.valid;
         next_payload = req_if.payload;
         if (!req_if.valid || req_taken) begin
            next_valid   = 1'b0;
            // junk on the bus while idle, the block must ignore it
            next_payload = REQ_W'($urandom);
            if (gap_left > 0) begin
               gap_left--;
            end else if (instr_q.size() > 0 &&
                         !(instr_q[0].hold && result_q.size() > 0)) begin
               next_payload = instr_q[0].instr;
               next_valid   = 1'b1;
               instr_q.pop_front();
               if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct)
                  gap_left = $urandom_range(1, 19);
            end
         end
         req_if.valid   <= next_valid;
         req_if.payload <= next_payload;
      end
   end

   // receiver: ready drops in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left = $urandom_range(0, 18);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: predicts on each accepted instruction, checks each accepted result
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready)
            result_q.push_back(execute_instr(req_if.payload));
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (result_q.size() == 0) begin
               report_mismatch("unexpected transaction, next_pc", got.next_pc, '0);
            end else begin
               want = result_q.pop_front();
               if (got.wrote_register !== want.wrote_register)
                  report_mismatch("wrote_register", DATA_W'(got.wrote_register),
                                  DATA_W'(want.wrote_register));
               if (got.written_index !== want.written_index)
                  report_mismatch("written_index", DATA_W'(got.written_index),
                                  DATA_W'(want.written_index));
               if (got.written_value !== want.written_value)
                  report_mismatch("written_value", got.written_value, want.written_value);
               if (got.next_pc !== want.next_pc)
                  report_mismatch("next_pc", got.next_pc, want.next_pc);
               if (got.overflow_flag !== want.overflow_flag)
                  report_mismatch("overflow_flag", DATA_W'(got.overflow_flag),
                                  DATA_W'(want.overflow_flag));
               if (got.unknown_function !== want.unknown_function)
                  report_mismatch("unknown_function", DATA_W'(got.unknown_function),
                                  DATA_W'(want.unknown_function));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      for (int i = 0; i < REG_COUNT; i++)
         gpr_model[i] = '0;
      pc_model      = '0;
      req_gap_pct   = 15;
      rsp_stall_pct = 8;
      gap_left      = 0;
      stall_left    = 0;
      error_count   = 0;
      cycle_count   = 0;
      wait (reset === 1'b0);

      // build extreme values from the all-zero register file, then hit every operation
      push_instr(make_instr(FN_NOR,  0, 0, 1, 0), 1'b0);   // r1 all ones
      push_instr(make_instr(FN_SRL,  0, 1, 2, 1), 1'b0);   // r2 largest positive
      push_instr(make_instr(FN_SLL,  0, 1, 3, 31), 1'b0);  // r3 most negative
      push_instr(make_instr(FN_ADD,  2, 2, 4, 0), 1'b0);   // positive overflow
      push_instr(make_instr(FN_ADD,  3, 3, 5, 0), 1'b0);   // negative overflow
      push_instr(make_instr(FN_SUB,  3, 2, 6, 0), 1'b0);   // sub overflow to positive
      push_instr(make_instr(FN_SUB,  2, 1, 7, 0), 1'b0);   // sub overflow to negative
      push_instr(make_instr(FN_ADDU, 1, 1, 8, 0), 1'b0);   // carry out
      push_instr(make_instr(FN_SUBU, 0, 1, 9, 0), 1'b0);   // borrow
      push_instr(make_instr(FN_AND,  1, 2, 10, 0), 1'b0);
      push_instr(make_instr(FN_OR,   3, 2, 11, 0), 1'b0);
      push_instr(make_instr(FN_XOR,  1, 2, 12, 0), 1'b0);
      push_instr(make_instr(FN_NAND, 1, 3, 13, 0), 1'b0);
      push_instr(make_instr(FN_SLT,  3, 2, 14, 0), 1'b0);  // signed less
      push_instr(make_instr(FN_SLTU, 3, 2, 15, 0), 1'b0);  // not less unsigned
      push_instr(make_instr(FN_SRA,  0, 3, 16, 31), 1'b0); // sign fill all the way
      push_instr(make_instr(FN_SRA,  0, 2, 17, 0), 1'b0);  // zero distance
      push_instr(make_instr(FN_SLL,  0, 2, 18, 0), 1'b0);
      push_instr(make_instr(FN_JR,   2, 5, 19, 7), 1'b0);  // unaligned jump target
      push_instr(make_instr(FN_ADDU, 1, 0, 0, 0), 1'b0);   // register zero written
      push_instr(make_instr(FN_ADD,  0, 0, 31, 0), 1'b0);  // register zero read back
      push_instr(make_instr(FN_JR,   1, 0, 0, 0), 1'b0);   // pc to all ones
      push_instr(make_instr(FN_ADD,  2, 0, 20, 0), 1'b0);  // pc wraps past zero
      push_instr(make_instr(6'h3F,  31, 31, 31, 31), 1'b0); // unknown codes change nothing
      push_instr(make_instr(6'h01,   1, 2, 0, 0), 1'b0);
      wait_sent();

      // random phases: drain first, no idling, heavy gaps, heavy stalls, quiet tail
      run_phase(300, 25, 6, 1'b1);
      run_phase(300, 0, 0, 1'b0);
      run_phase(300, 50, 2, 1'b1);
      run_phase(250, 5, 20, 1'b0);
      run_phase(150, 0, 0, 1'b0);

      // drain and let any stray transaction show up
      while (req_if.valid || result_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/rfx_pkg.sv
rtl/rfx_stream_if.sv
rtl/rfx_front.sv
rtl/rfx_queue.sv
rtl/rfx_back.sv
rtl/rtype_alu_register_file.sv
tb/sv/tb_top.sv
